// File: rtl/core/pcg_pkg.sv
// Shared definitions for the PCG32 range generator: operation codes, LCG constants,
// the status struct passed from the serial units, and the XSH-RR output function.
// Depends on nothing.
`default_nettype none

package pcg_pkg;

    localparam logic [2:0] OP_SEED   = 3'd0;
    localparam logic [2:0] OP_RAW    = 3'd1;
    localparam logic [2:0] OP_INT31  = 3'd2;
    localparam logic [2:0] OP_FRAC24 = 3'd3;
    localparam logic [2:0] OP_URANGE = 3'd4;
    localparam logic [2:0] OP_SRANGE = 3'd5;

    localparam logic [63:0] PCG_MULTIPLIER  = 64'h5851f42d4c957f2d;
    localparam logic [63:0] PCG_RESET_STATE = 64'h853c49e6748fea9b;
    localparam logic [63:0] PCG_RESET_INC   = 64'hda3e39cb94b95bdb;

    typedef struct packed {
        logic busy;
        logic done;
    } pcg_status_t;

    // XSH-RR output permutation of the state before the step.
    function automatic logic [31:0] pcg_output(input logic [63:0] s);
        logic [63:0] folded;
        logic [31:0] mixed;
        logic [4:0]  rot;
        begin
            folded = ((s >> 18) ^ s) >> 27;
            mixed  = folded[31:0];
            rot    = s[63:59];
            pcg_output = (mixed >> rot) | (mixed << (6'd32 - {1'b0, rot}));
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/pcg32_random_with_range_core.sv
// Top level of the PCG32 XSH-RR generator with range draws.
// Depends on pcg_pkg, pcg_step and pcg_mod.
`default_nettype none

// One request is handled at a time. Each generator step runs through a
// bit-serial multiplier, with start and completion handshakes between it and
// the controller. A raw, int31 or fraction result is taken from the finished
// step into a result register and then passes through the output state.
// A seed request frees the input once its step is done. A range request with
// an empty range (low not below high) passes low to the output state without
// touching the generator state. Otherwise a serial remainder first finds the
// rejection limit. Each draw then costs one generator step, and a second
// serial remainder reduces the accepted draw; every rejected draw costs one
// more step. A finished result moves into an output register. The next
// request is taken while that result waits, but its own result is held back
// until the waiting one has gone. Undefined operation codes are absorbed
// with no result and no state change.
module pcg32_random_with_range_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  operation,
    input  wire logic [63:0] seed_value,
    input  wire logic [31:0] low_bound,
    input  wire logic [31:0] high_bound,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      random_value
);
    import pcg_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_LIMIT,
        ST_DRAW,
        ST_RSTEP,
        ST_RMOD,
        ST_OUT
    } state_t;

    state_t      state_reg;
    logic [63:0] gen_state_reg;
    logic [63:0] inc_reg;
    logic [2:0]  op_reg;
    logic [31:0] low_reg;
    logic [31:0] span_reg;
    logic [31:0] limit_reg;
    logic [31:0] draw_reg;
    logic [31:0] result_reg;
    logic [31:0] out_data_reg;
    logic        out_valid_reg;
    logic        step_start_reg;
    logic        mod_start_reg;
    logic [31:0] mod_dvd_reg;

    logic [63:0] step_next;
    logic [31:0] mod_rem;
    pcg_status_t step_status;
    pcg_status_t mod_status;
    logic        accept;
    logic        empty_range;
    logic [31:0] span;
    logic [31:0] draw_now;
    logic        out_take;
    logic        out_load;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign in_stall = (state_reg != ST_IDLE);
    assign span     = high_bound - low_bound;
    assign draw_now = pcg_output(gen_state_reg);

    // The output register is freed by a taken result and refilled from the
    // output state, possibly at the same edge.
    assign out_take = out_valid_reg && !out_stall;
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    // Signed ranges compare with the sign bits flipped.
    always_comb
    begin
        if (operation == OP_SRANGE)
        begin
            empty_range = ({~low_bound[31], low_bound[30:0]} >=
                           {~high_bound[31], high_bound[30:0]});
        end
        else
        begin
            empty_range = (low_bound >= high_bound);
        end
    end

    pcg_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (step_start_reg),
        .prev_state (gen_state_reg),
        .increment  (inc_reg),
        .next_state (step_next),
        .status     (step_status)
    );

    pcg_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start_reg),
        .dividend  (mod_dvd_reg),
        .divisor   (span_reg),
        .remainder (mod_rem),
        .status    (mod_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            gen_state_reg  <= PCG_RESET_STATE;
            inc_reg        <= PCG_RESET_INC;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= 32'd0;
            step_start_reg <= 1'b0;
            mod_start_reg  <= 1'b0;
            op_reg         <= OP_SEED;
        end
        else
        begin
            step_start_reg <= 1'b0;
            mod_start_reg  <= 1'b0;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= result_reg;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg   <= operation;
                        low_reg  <= low_bound;
                        span_reg <= span;
                        case (operation)
                            OP_SEED:
                            begin
                                // Stepping from a zero state yields the increment,
                                // so the first step folds into one addition.
                                inc_reg        <= {seed_value[62:0], 1'b1};
                                gen_state_reg  <= {seed_value[62:0], 1'b1} + seed_value;
                                step_start_reg <= 1'b1;
                                state_reg      <= ST_STEP;
                            end
                            OP_RAW, OP_INT31, OP_FRAC24:
                            begin
                                draw_reg       <= draw_now;
                                step_start_reg <= 1'b1;
                                state_reg      <= ST_STEP;
                            end
                            OP_URANGE, OP_SRANGE:
                            begin
                                if (empty_range)
                                begin
                                    result_reg <= low_bound;
                                    state_reg  <= ST_OUT;
                                end
                                else
                                begin
                                    mod_dvd_reg   <= 32'd0 - span;
                                    mod_start_reg <= 1'b1;
                                    state_reg     <= ST_LIMIT;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_STEP:
                begin
                    if (step_status.done)
                    begin
                        gen_state_reg <= step_next;
                        case (op_reg)
                            OP_RAW:    result_reg <= draw_reg;
                            OP_INT31:  result_reg <= draw_reg >> 1;
                            OP_FRAC24: result_reg <= draw_reg >> 8;
                            default:   result_reg <= draw_reg;
                        endcase
                        state_reg <= (op_reg == OP_SEED) ? ST_IDLE : ST_OUT;
                    end
                end
                ST_LIMIT:
                begin
                    if (mod_status.done)
                    begin
                        limit_reg <= mod_rem;
                        state_reg <= ST_DRAW;
                    end
                end
                ST_DRAW:
                begin
                    draw_reg       <= draw_now;
                    step_start_reg <= 1'b1;
                    state_reg      <= ST_RSTEP;
                end
                ST_RSTEP:
                begin
                    if (step_status.done)
                    begin
                        gen_state_reg <= step_next;
                        if (draw_reg < limit_reg)
                        begin
                            state_reg <= ST_DRAW;
                        end
                        else
                        begin
                            mod_dvd_reg   <= draw_reg;
                            mod_start_reg <= 1'b1;
                            state_reg     <= ST_RMOD;
                        end
                    end
                end
                ST_RMOD:
                begin
                    if (mod_status.done)
                    begin
                        result_reg <= low_reg + mod_rem;
                        state_reg  <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign random_value = out_data_reg;

`ifndef ASSERT_OFF
    // A step unit completion is only ever awaited in a stepping state.
    a_step_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        step_status.done |-> (state_reg == ST_STEP || state_reg == ST_RSTEP))
        else $error("step unit finished outside a stepping state");

    a_mod_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mod_status.done |-> (state_reg == ST_LIMIT || state_reg == ST_RMOD))
        else $error("remainder unit finished outside a remainder state");

    // A new result is only ever raised from the output state.
    a_out_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output state");

    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(step_status.busy && mod_status.busy))
        else $error("step and remainder units busy together");
`endif

endmodule

`default_nettype wire

// File: rtl/core/pcg_step.sv
// Serial LCG step unit: new = prev * multiplier + inc, one multiplier bit per cycle.
// Depends on pcg_pkg.
`default_nettype none

module pcg_step (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [63:0]        prev_state,
    input  wire logic [63:0]        increment,
    output logic [63:0]             next_state,
    output pcg_pkg::pcg_status_t    status
);
    import pcg_pkg::*;

    logic [63:0] acc_reg;
    logic [63:0] mcand_reg;
    logic [63:0] mult_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // One partial product is added each cycle as the multiplier shifts out.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg   <= increment;
            mcand_reg <= prev_state;
            mult_reg  <= PCG_MULTIPLIER;
        end
        else if (busy_reg)
        begin
            if (mult_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg <= mcand_reg << 1;
            mult_reg  <= mult_reg >> 1;
        end
    end

    assign next_state  = acc_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

// File: rtl/core/pcg_mod.sv
// Serial 32-bit remainder unit, restoring division one dividend bit per cycle.
// Depends on pcg_pkg.
`default_nettype none

module pcg_mod (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [31:0]        dividend,
    input  wire logic [31:0]        divisor,
    output logic [31:0]             remainder,
    output pcg_pkg::pcg_status_t    status
);
    import pcg_pkg::*;

    logic [31:0] rem_reg;
    logic [31:0] dvd_reg;
    logic [31:0] dsr_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;
    logic [32:0] diff;

    assign trial = {rem_reg, dvd_reg[31]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= 32'd0;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // The partial remainder stays below the divisor, so it fits 32 bits.
            if (!diff[32])
            begin
                rem_reg <= diff[31:0];
            end
            else
            begin
                rem_reg <= trial[31:0];
            end
            dvd_reg <= dvd_reg << 1;
        end
    end

    assign remainder   = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire
